### rtl/tvtb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tvtb_pkg: shared types and constants
// Control/status bundles, controller states and interval constants used by
// the trade volume time bucket unit.
// ----------------------------------------------------------------------------
package tvtb_pkg;

   localparam int TIME_WIDTH_DEFAULT = 32;
   localparam int SUM_WIDTH_DEFAULT  = 48;

   localparam int                IV_WIDTH = 17;
   localparam logic [IV_WIDTH-1:0] IV_RESET = 17'd60;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIV,
      ST_PUT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;   // capture the request word
      logic eval;   // classify trade and update state
      logic step;   // one remainder step of the bucket rounding
      logic put;    // load the response register
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic need_div;  // trade opens a bucket, rounding required
      logic div_done;  // last remainder step in progress
      logic rsp_free;  // response register can take a word
   } dp_status_type;

endpackage : tvtb_pkg
`default_nettype wire

### rtl/tvtb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tvtb_ctrl: sequencing controller
// Accepts one request word, steps the datapath through classification,
// serial rounding when a bucket opens, and the response load.
// ----------------------------------------------------------------------------
module tvtb_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire tvtb_pkg::dp_status_type status,
   output tvtb_pkg::ctrl_cmd_type       cmd
);
   import tvtb_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            state_in = status.need_div ? ST_DIV : ST_PUT;
         end
         ST_DIV: begin
            if (status.div_done) state_in = ST_PUT;
         end
         ST_PUT: begin
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_EVAL: cmd.eval = 1'b1;
         ST_DIV:  cmd.step = 1'b1;
         ST_PUT:  cmd.put  = status.rsp_free;
         default: req_stall = 1'b1;
      endcase
   end

endmodule : tvtb_ctrl
`default_nettype wire

### rtl/tvtb_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tvtb_dp: bucket datapath
// Holds the interval register, bucket state, a one-bit-per-cycle remainder
// unit for rounding a trade time down to the interval, and the response
// register.
// ----------------------------------------------------------------------------
module tvtb_dp #(
   parameter int TIME_WIDTH = tvtb_pkg::TIME_WIDTH_DEFAULT,
   parameter int SUM_WIDTH  = tvtb_pkg::SUM_WIDTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire tvtb_pkg::ctrl_cmd_type            cmd,
   output tvtb_pkg::dp_status_type                status,
   input  wire logic                              csr_valid,
   input  wire logic [tvtb_pkg::IV_WIDTH-1:0]     csr_interval_seconds,
   input  wire logic                              req_cmd,
   input  wire logic [TIME_WIDTH-1:0]             req_trade_time,
   input  wire logic [SUM_WIDTH-1:0]              req_trade_amount,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [TIME_WIDTH-1:0]                  rsp_bucket_start_time,
   output logic [SUM_WIDTH-1:0]                   rsp_bucket_volume,
   output logic                                   rsp_opened_new_bucket,
   output logic                                   rsp_trade_dropped,
   output logic                                   rsp_volume_saturated,
   output logic                                   rsp_buckets_empty
);
   import tvtb_pkg::*;

   localparam int CW    = (TIME_WIDTH > IV_WIDTH) ? TIME_WIDTH : IV_WIDTH;
   localparam int CNT_W = (TIME_WIDTH > 1) ? $clog2(TIME_WIDTH) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TIME_WIDTH - 1);

   // configuration
   logic [IV_WIDTH-1:0] iv_ff;
   logic [IV_WIDTH-1:0] iv_eff;

   // captured request word
   logic                  cmd_ff;
   logic [TIME_WIDTH-1:0] time_ff;
   logic [SUM_WIDTH-1:0]  amt_ff;

   // bucket state
   logic                  any_seen_ff;
   logic [TIME_WIDTH-1:0] last_ff;
   logic [TIME_WIDTH-1:0] start_ff;
   logic [SUM_WIDTH-1:0]  sum_ff;
   logic                  opened_ff;
   logic                  dropped_ff;

   // remainder unit
   logic [IV_WIDTH-1:0]   rem_ff;
   logic [IV_WIDTH-1:0]   rem_in;
   logic [TIME_WIDTH-1:0] shift_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [IV_WIDTH:0]     rem_shifted;
   logic [IV_WIDTH:0]     rem_sub;

   // response register
   logic                  rsp_valid_ff;
   logic [TIME_WIDTH-1:0] rsp_start_ff;
   logic [SUM_WIDTH-1:0]  rsp_sum_ff;
   logic                  rsp_opened_ff;
   logic                  rsp_dropped_ff;
   logic                  rsp_sat_ff;
   logic                  rsp_empty_ff;

   logic                  is_older;
   logic                  in_bucket;
   logic [TIME_WIDTH-1:0] diff;
   logic [SUM_WIDTH:0]    sum_wide;
   logic [SUM_WIDTH-1:0]  sum_sat;
   logic [CW-1:0]         start_wide;

   assign iv_eff = (iv_ff == '0) ? IV_WIDTH'(1) : iv_ff;

   always_comb begin
      is_older  = any_seen_ff && (time_ff < last_ff);
      diff      = time_ff - start_ff;
      in_bucket = any_seen_ff && (time_ff >= start_ff) && (CW'(diff) < CW'(iv_eff));
      sum_wide  = {1'b0, sum_ff} + {1'b0, amt_ff};
      sum_sat   = sum_wide[SUM_WIDTH] ? '1 : sum_wide[SUM_WIDTH-1:0];
   end

   // restoring remainder step: bring in one time bit, subtract interval if it fits
   always_comb begin
      rem_shifted = {rem_ff, shift_ff[TIME_WIDTH-1]};
      rem_sub     = rem_shifted - {1'b0, iv_eff};
      rem_in      = (rem_shifted >= {1'b0, iv_eff}) ? rem_sub[IV_WIDTH-1:0]
                                                    : rem_shifted[IV_WIDTH-1:0];
      start_wide  = CW'(time_ff) - CW'(rem_in);
   end

   always_comb begin
      status.need_div = !cmd_ff && !is_older && !in_bucket;
      status.div_done = (cnt_ff == CNT_LAST);
      status.rsp_free = !rsp_valid_ff || !rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iv_ff <= IV_RESET;
      end else if (csr_valid) begin
         iv_ff <= csr_interval_seconds;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff  <= req_cmd;
         time_ff <= req_trade_time;
         amt_ff  <= req_trade_amount;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         any_seen_ff <= 1'b0;
         last_ff     <= '0;
         start_ff    <= '0;
         sum_ff      <= '0;
         opened_ff   <= 1'b0;
         dropped_ff  <= 1'b0;
      end else if (cmd.eval) begin
         opened_ff  <= 1'b0;
         dropped_ff <= 1'b0;
         if (cmd_ff) begin
            any_seen_ff <= 1'b0;
            last_ff     <= '0;
            start_ff    <= '0;
            sum_ff      <= '0;
         end else if (is_older) begin
            dropped_ff <= 1'b1;
         end else if (in_bucket) begin
            last_ff <= time_ff;
            sum_ff  <= sum_sat;
         end else begin
            // open a bucket; its start lands after the last remainder step
            any_seen_ff <= 1'b1;
            last_ff     <= time_ff;
            sum_ff      <= amt_ff;
            opened_ff   <= 1'b1;
         end
      end else if (cmd.step && status.div_done) begin
         start_ff <= start_wide[TIME_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         rem_ff   <= '0;
         shift_ff <= time_ff;
         cnt_ff   <= '0;
      end else if (cmd.step) begin
         rem_ff   <= rem_in;
         shift_ff <= {shift_ff[TIME_WIDTH-2:0], 1'b0};
         cnt_ff   <= cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.put) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.put) begin
         rsp_start_ff   <= start_ff;
         rsp_sum_ff     <= sum_ff;
         rsp_opened_ff  <= opened_ff;
         rsp_dropped_ff <= dropped_ff;
         rsp_sat_ff     <= any_seen_ff && (sum_ff == '1);
         rsp_empty_ff   <= !any_seen_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_bucket_start_time = rsp_start_ff;
   assign rsp_bucket_volume     = rsp_sum_ff;
   assign rsp_opened_new_bucket = rsp_opened_ff;
   assign rsp_trade_dropped     = rsp_dropped_ff;
   assign rsp_volume_saturated  = rsp_sat_ff;
   assign rsp_buckets_empty     = rsp_empty_ff;

endmodule : tvtb_dp
`default_nettype wire

### rtl/trade_volume_time_buckets_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trade_volume_time_buckets_unit: time bucket volume aggregator
// Sums trade amounts into buckets of a programmable length in seconds.
//
// req_ channel: one word per trade (req_cmd 0) or clear (req_cmd 1). The
// unit takes one word at a time; req_stall is high from the accept edge
// until the response has been loaded into the output register.
// rsp_ channel: one response word per request, held in an output register,
// so the next request is taken while that response still waits.
// csr_ channel: interval_seconds, always ready; write only while idle.
// Flow: clear, dropped and in-bucket trades go from evaluation straight to the
// response load; a trade that opens a bucket first passes through the
// one-bit-per-cycle remainder unit, which rounds the time down to the
// interval, one step per time bit.
// Reset: interval returns to 60, bucket state empties, no response pending.
// A stalled rsp_ holds its word; the unit finishes the next item and waits
// in its output state until the register frees up.
// ----------------------------------------------------------------------------
module trade_volume_time_buckets_unit #(
   parameter int TIME_WIDTH = tvtb_pkg::TIME_WIDTH_DEFAULT,
   parameter int SUM_WIDTH  = tvtb_pkg::SUM_WIDTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [tvtb_pkg::IV_WIDTH-1:0] csr_interval_seconds,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_cmd,
   input  wire logic [TIME_WIDTH-1:0]         req_trade_time,
   input  wire logic [SUM_WIDTH-1:0]          req_trade_amount,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [TIME_WIDTH-1:0]              rsp_bucket_start_time,
   output logic [SUM_WIDTH-1:0]               rsp_bucket_volume,
   output logic                               rsp_opened_new_bucket,
   output logic                               rsp_trade_dropped,
   output logic                               rsp_volume_saturated,
   output logic                               rsp_buckets_empty
);
   import tvtb_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   tvtb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tvtb_dp #(
      .TIME_WIDTH (TIME_WIDTH),
      .SUM_WIDTH  (SUM_WIDTH)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .csr_valid             (csr_valid),
      .csr_interval_seconds  (csr_interval_seconds),
      .req_cmd               (req_cmd),
      .req_trade_time        (req_trade_time),
      .req_trade_amount      (req_trade_amount),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_bucket_start_time (rsp_bucket_start_time),
      .rsp_bucket_volume     (rsp_bucket_volume),
      .rsp_opened_new_bucket (rsp_opened_new_bucket),
      .rsp_trade_dropped     (rsp_trade_dropped),
      .rsp_volume_saturated  (rsp_volume_saturated),
      .rsp_buckets_empty     (rsp_buckets_empty)
   );

endmodule : trade_volume_time_buckets_unit
`default_nettype wire
